>>> rtl/core/text_encoding_detector_unit_assert.svh
// Assertion macros for the text encoding detector
`ifndef TEXT_ENCODING_DETECTOR_UNIT_ASSERT_SVH
`define TEXT_ENCODING_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define TED_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define TED_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/ted_pkg.sv
`default_nettype none

package ted_pkg;

   typedef enum logic [1:0] {
      ENC_LATIN1 = 2'd0,
      ENC_UTF8   = 2'd1,
      ENC_EUCKR  = 2'd2,
      ENC_SJIS   = 2'd3
   } encoding_type;

   localparam logic [7:0] BYTE_LF         = 8'h0A;
   localparam logic [7:0] EUC_LO          = 8'hA1;
   localparam logic [7:0] EUC_HI          = 8'hFE;
   localparam logic [7:0] KANA_LO         = 8'hA1;
   localparam logic [7:0] KANA_HI         = 8'hDF;
   localparam logic [7:0] SJIS_LEAD_LO    = 8'h81;
   localparam logic [7:0] SJIS_LEAD_HI    = 8'h9F;
   localparam logic [7:0] SJIS_LEAD2_LO   = 8'hE0;
   localparam logic [7:0] SJIS_LEAD2_HI   = 8'hFC;
   localparam logic [7:0] SJIS_TRAIL_LO   = 8'h40;
   localparam logic [7:0] SJIS_TRAIL_MID1 = 8'h7E;
   localparam logic [7:0] SJIS_TRAIL_MID2 = 8'h80;
   localparam logic [7:0] SJIS_TRAIL_HI   = 8'hFC;

   typedef struct packed {
      logic       high_byte;
      logic       utf8_valid;
      logic [2:0] utf8_owed;
      logic       euckr_valid;
      logic       euckr_owed;
      logic       sjis_valid;
      logic       sjis_owed;
   } line_state_type;

   localparam line_state_type LINE_START = '{
      high_byte:   1'b0,
      utf8_valid:  1'b1,
      utf8_owed:   3'd0,
      euckr_valid: 1'b1,
      euckr_owed:  1'b0,
      sjis_valid:  1'b1,
      sjis_owed:   1'b0
   };

   typedef struct packed {
      logic         decide;
      encoding_type enc;
   } line_verdict_type;

   function automatic line_verdict_type close_line(input line_state_type line);
      line_verdict_type res;
      res.decide = 1'b0;
      res.enc    = ENC_LATIN1;
      if (line.high_byte) begin
         priority if (line.utf8_valid && line.utf8_owed == 3'd0) begin
            res.decide = 1'b1;
            res.enc    = ENC_UTF8;
         end else if (line.euckr_valid && !line.euckr_owed) begin
            res.decide = 1'b1;
            res.enc    = ENC_EUCKR;
         end else if (line.sjis_valid && !line.sjis_owed) begin
            res.decide = 1'b1;
            res.enc    = ENC_SJIS;
         end else begin
            res.decide = 1'b0;
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/ted_req_if.sv
`default_nettype none

interface ted_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink (input valid, input mode, input data_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ted_rsp_if.sv
`default_nettype none

interface ted_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] encoding;

   modport source (output valid, output encoding, input ready);
   modport sink (input valid, input encoding, output ready);
endinterface

`default_nettype wire

>>> rtl/core/text_encoding_detector_unit.sv
// Text encoding detector.
// req_chan carries one file byte per transfer (mode 0) or an end-of-file
// marker (mode 1, byte ignored). A 0x0A byte closes the current line.
// rsp_chan carries one encoding per end of file: 0 Latin-1, 1 UTF-8,
// 2 EUC-KR, 3 Shift-JIS. Data bytes never produce a response.
// Throughput: one transfer per cycle while no end of file waits for a free
// response slot, set by the line state update that feeds back on itself
// through the line and verdict registers. An end of file passes from the
// input register to the response register, which drives rsp_chan.valid.
// Reset clears the verdict, the line state and both stage valids; the block
// accepts transfers as soon as reset is released.
// When rsp_chan stalls, the response is held; following data bytes still
// flow, and a second end of file waits in the input register, which then
// holds req_chan.ready low until the response slot frees.
// After end of file the detector returns to its reset state for the next file.
`default_nettype none

module text_encoding_detector_unit (
   input  logic      clock,
   input  logic      reset,
   ted_req_if.sink   req_chan,
   ted_rsp_if.source rsp_chan
);
   import ted_pkg::*;

   logic             s1_valid_ff;
   logic             s1_valid_in;
   logic             s1_mode_ff;
   logic [7:0]       s1_byte_ff;
   logic             accept;
   logic             advance;
   logic             out_free;

   logic             verdict_fixed_ff;
   logic             verdict_fixed_in;
   encoding_type     verdict_ff;
   encoding_type     verdict_in;
   line_state_type   line_ff;
   line_state_type   line_in;
   line_state_type   line_next;
   line_verdict_type closing;
   logic             out_load;
   encoding_type     out_enc;

   assign advance        = s1_valid_ff && (!s1_mode_ff || out_free);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff <= req_chan.mode;
         s1_byte_ff <= req_chan.data_byte;
      end
   end

   ted_line_check u_line_check (
      .line_in   (line_ff),
      .data_byte (s1_byte_ff),
      .line_out  (line_next)
   );

   assign closing = close_line(line_ff);

   always_comb begin
      verdict_fixed_in = verdict_fixed_ff;
      verdict_in       = verdict_ff;
      line_in          = line_ff;
      out_load         = 1'b0;
      out_enc          = verdict_ff;
      if (advance) begin
         priority if (s1_mode_ff) begin
            out_load         = 1'b1;
            out_enc          = (!verdict_fixed_ff && closing.decide) ? closing.enc
                                                                     : verdict_ff;
            verdict_fixed_in = 1'b0;
            verdict_in       = ENC_LATIN1;
            line_in          = LINE_START;
         end else if (verdict_fixed_ff) begin
            line_in = line_ff;
         end else if (s1_byte_ff == BYTE_LF) begin
            if (closing.decide) begin
               verdict_fixed_in = 1'b1;
               verdict_in       = closing.enc;
            end
            line_in = LINE_START;
         end else begin
            line_in = line_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         verdict_fixed_ff <= 1'b0;
         verdict_ff       <= ENC_LATIN1;
         line_ff          <= LINE_START;
      end else begin
         verdict_fixed_ff <= verdict_fixed_in;
         verdict_ff       <= verdict_in;
         line_ff          <= line_in;
      end
   end

   ted_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (out_load),
      .load_enc (out_enc),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

`include "text_encoding_detector_unit_assert.svh"

   `TED_ASSERT_IMPLY(a_eof_stall, clock, reset,
      s1_valid_ff && s1_mode_ff && !out_free, !req_chan.ready)
   `TED_ASSERT_NEXT(a_eof_emits, clock, reset,
      advance && s1_mode_ff, rsp_chan.valid)
   `TED_ASSERT_NEXT(a_eof_clears, clock, reset,
      advance && s1_mode_ff, !verdict_fixed_ff && line_ff == LINE_START)
   `TED_ASSERT_IMPLY(a_fixed_idle_line, clock, reset,
      verdict_fixed_ff, line_ff == LINE_START)

endmodule

`default_nettype wire

>>> rtl/core/ted_line_check.sv
`default_nettype none

module ted_line_check (
   input  ted_pkg::line_state_type line_in,
   input  logic [7:0]              data_byte,
   output ted_pkg::line_state_type line_out
);
   import ted_pkg::*;

   logic [7:0] b;
   logic       cont;
   logic       sjis_trail_ok;

   assign b             = data_byte;
   assign cont          = (b[7:6] == 2'b10);
   assign sjis_trail_ok = (b >= SJIS_TRAIL_LO && b <= SJIS_TRAIL_MID1) ||
                          (b >= SJIS_TRAIL_MID2 && b <= SJIS_TRAIL_HI);

   always_comb begin
      line_out = line_in;
      if (b[7]) begin
         line_out.high_byte = 1'b1;
      end

      if (line_in.utf8_valid) begin
         if (line_in.utf8_owed != 3'd0) begin
            if (cont) begin
               line_out.utf8_owed = line_in.utf8_owed - 3'd1;
            end else begin
               line_out.utf8_valid = 1'b0;
               line_out.utf8_owed  = 3'd0;
            end
         end else begin
            priority if (cont || b[7:1] == 7'h7F) begin
               line_out.utf8_valid = 1'b0;
            end else if (!b[7]) begin
               line_out.utf8_owed = 3'd0;
            end else if (b[7:5] == 3'b110) begin
               line_out.utf8_owed = 3'd1;
            end else if (b[7:4] == 4'b1110) begin
               line_out.utf8_owed = 3'd2;
            end else if (b[7:3] == 5'b11110) begin
               line_out.utf8_owed = 3'd3;
            end else if (b[7:2] == 6'b111110) begin
               line_out.utf8_owed = 3'd4;
            end else begin
               line_out.utf8_owed = 3'd5;
            end
         end
      end

      if (line_in.euckr_valid) begin
         if (line_in.euckr_owed) begin
            line_out.euckr_owed = 1'b0;
            if (b < EUC_LO || b > EUC_HI) begin
               line_out.euckr_valid = 1'b0;
            end
         end else if (b[7]) begin
            if (b >= EUC_LO && b <= EUC_HI) begin
               line_out.euckr_owed = 1'b1;
            end else begin
               line_out.euckr_valid = 1'b0;
            end
         end
      end

      if (line_in.sjis_valid) begin
         if (line_in.sjis_owed) begin
            line_out.sjis_owed = 1'b0;
            if (!sjis_trail_ok) begin
               line_out.sjis_valid = 1'b0;
            end
         end else if (b[7]) begin
            priority if (b >= KANA_LO && b <= KANA_HI) begin
               line_out.sjis_owed = 1'b0;
            end else if ((b >= SJIS_LEAD_LO && b <= SJIS_LEAD_HI) ||
                         (b >= SJIS_LEAD2_LO && b <= SJIS_LEAD2_HI)) begin
               line_out.sjis_owed = 1'b1;
            end else begin
               line_out.sjis_valid = 1'b0;
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/ted_out_reg.sv
`default_nettype none

module ted_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  ted_pkg::encoding_type load_enc,
   output logic                  free,
   ted_rsp_if.source             rsp_chan
);
   import ted_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   encoding_type enc_ff;

   assign free              = !valid_ff || rsp_chan.ready;
   assign rsp_chan.valid    = valid_ff;
   assign rsp_chan.encoding = enc_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         enc_ff <= load_enc;
      end
   end

endmodule

`default_nettype wire

>>> bench/tb_text_encoding_detector_unit.sv
module tb_text_encoding_detector_unit;
   import ted_pkg::*;

   localparam int          CYCLE_LIMIT = 200000;
   localparam int          BYTE_TARGET = 1226;
   localparam int          IDLE_PCT    = 22;
   localparam int          STALL_LEN   = 80;
   localparam logic [7:0]  LF          = 8'h0A;

   typedef enum int {
      LINE_ASCII, LINE_UTF8, LINE_EUCKR, LINE_SJIS, LINE_NOISE
   } line_kind_type;

   typedef struct {
      bit       pause;
      bit       mode;
      bit [7:0] data;
   } file_byte_type;

   typedef struct {
      bit           fixed;
      encoding_type verdict;
      bit           high;
      bit           u_ok;
      bit [2:0]     u_owed;
      bit           e_ok;
      bit           e_owed;
      bit           s_ok;
      bit           s_owed;
   } sniff_state_type;

   logic clock = 1'b0;
   logic reset;

   ted_req_if req_chan();
   ted_rsp_if rsp_chan();

   text_encoding_detector_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   file_byte_type   byte_backlog[$];
   encoding_type    enc_expected[$];
   sniff_state_type sn;
   int           byte_plan    = 0;
   int           bytes_taken  = 0;
   int           results_seen = 0;
   int           cycle_count  = 0;
   int           stall_left   = 0;
   bit           stall_done   = 0;
   bit           req_fire     = 0;
   bit           mismatch_seen = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor

   function automatic void clear_line();
      sn.high   = 0;
      sn.u_ok   = 1;
      sn.u_owed = 3'd0;
      sn.e_ok   = 1;
      sn.e_owed = 0;
      sn.s_ok   = 1;
      sn.s_owed = 0;
   endfunction

   function automatic void settle_line();
      if (!sn.fixed && sn.high) begin
         if (sn.u_ok && sn.u_owed == 3'd0) begin
            sn.verdict = ENC_UTF8;
            sn.fixed   = 1;
         end else if (sn.e_ok && !sn.e_owed) begin
            sn.verdict = ENC_EUCKR;
            sn.fixed   = 1;
         end else if (sn.s_ok && !sn.s_owed) begin
            sn.verdict = ENC_SJIS;
            sn.fixed   = 1;
         end
      end
      clear_line();
   endfunction

   function automatic void utf8_step(input bit [7:0] b);
      if (sn.u_ok) begin
         if (sn.u_owed != 3'd0) begin
            if (b[7:6] == 2'b10) begin
               sn.u_owed = sn.u_owed - 3'd1;
            end else begin
               sn.u_ok   = 0;
               sn.u_owed = 3'd0;
            end
         end else if (b[7:6] == 2'b10 || b[7:1] == 7'h7F) begin
            sn.u_ok = 0;
         end else if (b[7]) begin
            casez (b[6:2])
               5'b10???: sn.u_owed = 3'd1;
               5'b110??: sn.u_owed = 3'd2;
               5'b1110?: sn.u_owed = 3'd3;
               5'b11110: sn.u_owed = 3'd4;
               default:  sn.u_owed = 3'd5;
            endcase
         end
      end
   endfunction

   function automatic void euckr_step(input bit [7:0] b);
      if (sn.e_ok) begin
         if (sn.e_owed) begin
            sn.e_owed = 0;
            if (b < 8'hA1 || b > 8'hFE) sn.e_ok = 0;
         end else if (b[7]) begin
            if (b >= 8'hA1 && b <= 8'hFE) sn.e_owed = 1;
            else sn.e_ok = 0;
         end
      end
   endfunction

   function automatic void sjis_step(input bit [7:0] b);
      if (sn.s_ok) begin
         if (sn.s_owed) begin
            sn.s_owed = 0;
            if (!((b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC))) sn.s_ok = 0;
         end else if (b[7] && !(b >= 8'hA1 && b <= 8'hDF)) begin
            if ((b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC)) sn.s_owed = 1;
            else sn.s_ok = 0;
         end
      end
   endfunction

   function automatic bit sniff_byte(input bit mode, input bit [7:0] b,
                                     output encoding_type enc);
      enc = ENC_LATIN1;
      if (mode) begin
         settle_line();
         enc        = sn.verdict;
         sn.fixed   = 0;
         sn.verdict = ENC_LATIN1;
         clear_line();
         return 1;
      end
      if (!sn.fixed) begin
         if (b == LF) begin
            settle_line();
         end else begin
            if (b[7]) sn.high = 1;
            utf8_step(b);
            euckr_step(b);
            sjis_step(b);
         end
      end
      return 0;
   endfunction

   // stimulus builders

   function automatic void push_byte(input bit mode, input bit [7:0] b);
      file_byte_type fb;
      fb.pause = 0;
      fb.mode  = mode;
      fb.data  = b;
      byte_backlog.push_back(fb);
      byte_plan++;
   endfunction

   function automatic void push_pause();
      file_byte_type fb;
      fb.pause = 1;
      fb.mode  = 0;
      fb.data  = 8'h00;
      byte_backlog.push_back(fb);
   endfunction

   function automatic bit [7:0] rand_byte(input int lo, input int hi);
      return 8'($urandom_range(lo, hi));
   endfunction

   function automatic bit [7:0] ascii_byte();
      bit [7:0] b;
      do b = rand_byte(0, 127); while (b == LF);
      return b;
   endfunction

   function automatic void push_char(input line_kind_type kind, input bit cut);
      int       len;
      int       sent;
      bit [7:0] lead;
      case (kind)
         LINE_UTF8: begin
            len  = $urandom_range(2, 6);
            lead = rand_byte(0, 255);
            case (len)
               2:       lead[7:5] = 3'b110;
               3:       lead[7:4] = 4'b1110;
               4:       lead[7:3] = 5'b11110;
               5:       lead[7:2] = 6'b111110;
               default: lead[7:1] = 7'b1111110;
            endcase
            sent = cut ? $urandom_range(1, len - 1) : 0;
            push_byte(1'b0, lead);
            for (int i = 1; i < len - sent; i++) push_byte(1'b0, rand_byte(8'h80, 8'hBF));
         end
         LINE_EUCKR: begin
            push_byte(1'b0, rand_byte(8'hA1, 8'hFE));
            if (!cut) push_byte(1'b0, rand_byte(8'hA1, 8'hFE));
         end
         default: begin
            if (!cut && $urandom_range(2) == 0) begin
               push_byte(1'b0, rand_byte(8'hA1, 8'hDF));
            end else begin
               if ($urandom_range(1)) push_byte(1'b0, rand_byte(8'h81, 8'h9F));
               else push_byte(1'b0, rand_byte(8'hE0, 8'hFC));
               if (!cut) begin
                  if ($urandom_range(1)) push_byte(1'b0, rand_byte(8'h40, 8'h7E));
                  else push_byte(1'b0, rand_byte(8'h80, 8'hFC));
               end
            end
         end
      endcase
   endfunction

   function automatic void push_line(input line_kind_type kind, input bit cut);
      int chars;
      bit last;
      chars = $urandom_range(1, 5);
      for (int i = 0; i < chars; i++) begin
         last = (i == chars - 1);
         if (kind == LINE_NOISE) push_byte(1'b0, rand_byte(0, 255));
         else if (kind == LINE_ASCII || (!(cut && last) && $urandom_range(3) == 0))
            push_byte(1'b0, ascii_byte());
         else push_char(kind, cut && last);
      end
   endfunction

   function automatic void push_file();
      int            lines;
      line_kind_type kind;
      bit            cut;
      lines = $urandom_range(1, 4);
      for (int i = 0; i < lines; i++) begin
         cut = 0;
         case ($urandom_range(9))
            0, 1:    kind = LINE_ASCII;
            2, 3:    kind = LINE_UTF8;
            4, 5:    kind = LINE_EUCKR;
            6, 7:    kind = LINE_SJIS;
            8:       kind = LINE_NOISE;
            default: begin
               kind = line_kind_type'($urandom_range(1, 3));
               cut  = 1;
            end
         endcase
         push_line(kind, cut);
         if (i < lines - 1 || $urandom_range(1)) push_byte(1'b0, LF);
      end
      push_byte(1'b1, rand_byte(0, 255));
   endfunction

   function automatic bit calm_window();
      return cycle_count >= 600 && cycle_count < 900;
   endfunction

   // request driver

   always @(negedge clock) begin
      if (!reset && (!req_chan.valid || req_fire)) begin
         if (byte_backlog.size() > 0 && byte_backlog[0].pause && enc_expected.size() == 0)
            byte_backlog.delete(0);
         if (byte_backlog.size() > 0 && !byte_backlog[0].pause &&
             (calm_window() || $urandom_range(99) >= IDLE_PCT)) begin
            req_chan.valid     <= 1'b1;
            req_chan.mode      <= byte_backlog[0].mode;
            req_chan.data_byte <= byte_backlog[0].data;
            byte_backlog.delete(0);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= stall_left - 1;
      end else if (!stall_done && results_seen >= 12) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= STALL_LEN;
         stall_done     <= 1'b1;
      end else begin
         rsp_chan.ready <= calm_window() || $urandom_range(99) >= IDLE_PCT;
      end
   end

   // predict on each request transfer

   always @(posedge clock) begin
      encoding_type enc;
      req_fire <= !reset && req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready) begin
         bytes_taken++;
         if (sniff_byte(req_chan.mode, req_chan.data_byte, enc)) enc_expected.push_back(enc);
      end
   end

   // check each response transfer

   always @(posedge clock) begin
      encoding_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (enc_expected.size() == 0) begin
            $display("%0t unexpected encoding: expected none, actual %0d",
                     $time, rsp_chan.encoding);
            mismatch_seen = 1;
         end else begin
            want = enc_expected.pop_front();
            if (rsp_chan.encoding !== want) begin
               $display("%0t encoding mismatch: expected %0d, actual %0d",
                        $time, want, rsp_chan.encoding);
               mismatch_seen = 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.mode      = 1'b0;
      req_chan.data_byte = 8'h00;
      rsp_chan.ready     = 1'b0;
      sn.fixed           = 0;
      sn.verdict         = ENC_LATIN1;
      clear_line();

      // empty file
      push_byte(1'b1, 8'hFF);
      // plain ASCII
      push_byte(1'b0, 8'h41);
      push_byte(1'b0, LF);
      push_byte(1'b1, 8'h00);
      // six-byte UTF-8 lead
      push_byte(1'b0, 8'hFC);
      for (int i = 0; i < 5; i++) push_byte(1'b0, 8'h80);
      push_byte(1'b1, 8'h5A);
      // EUC-KR pair
      push_byte(1'b0, 8'hB0);
      push_byte(1'b0, 8'hA1);
      push_byte(1'b1, 8'hA5);
      // Shift-JIS lead with low trail
      push_byte(1'b0, 8'h81);
      push_byte(1'b0, 8'h40);
      push_byte(1'b1, 8'h01);
      // cut-off lead, all-invalid line, then UTF-8, then bytes after the verdict
      push_byte(1'b0, 8'hE0);
      push_byte(1'b0, LF);
      push_byte(1'b0, 8'hFF);
      push_byte(1'b0, LF);
      push_byte(1'b0, 8'hC3);
      push_byte(1'b0, 8'hA9);
      push_byte(1'b0, LF);
      push_byte(1'b0, 8'h8E);
      push_byte(1'b1, 8'h80);

      for (int f = 0; byte_plan < BYTE_TARGET; f++) begin
         if (f == 30) push_pause();
         push_file();
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (bytes_taken == byte_plan);
      wait (enc_expected.size() == 0);
      repeat (8) @(posedge clock);
      if (!mismatch_seen) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
